>>> src/contiguous_frame_allocator_core_assert.svh
// assertion macros used by the frame allocator sequencer
`ifndef CONTIGUOUS_FRAME_ALLOCATOR_CORE_ASSERT_SVH
`define CONTIGUOUS_FRAME_ALLOCATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define CFA_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define CFA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define CFA_ASSERT_SAME(label, ante, cons)
`define CFA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> src/cfa_pkg.sv
// shared types and constants of the frame allocator
`timescale 1ns / 1ps
package cfa_pkg;

	localparam logic [1:0] CMD_INIT  = 2'd0;
	localparam logic [1:0] CMD_ALLOC = 2'd1;
	localparam logic [1:0] CMD_FREE  = 2'd2;

	localparam logic REG_SEARCH_START = 1'b0;
	localparam logic REG_RESERVED     = 1'b1;

	localparam int CMD_W   = 2;
	localparam int FRAME_W = 10;
	localparam int COUNT_W = 11;

	typedef enum logic [2:0] {
		ST_BOOT,
		ST_IDLE,
		ST_SCAN,
		ST_FILL,
		ST_RESP
	} state_t;

	typedef enum logic [1:0] {
		DP_HOLD,
		DP_LOAD,
		DP_SCAN,
		DP_FILL
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} ctl_t;

	typedef struct packed {
		logic go_scan;
		logic found;
		logic exhausted;
		logic fill_done;
	} sts_t;

endpackage

>>> src/cfa_ctrl.sv
// command sequencer of the frame allocator
`timescale 1ns / 1ps
`include "contiguous_frame_allocator_core_assert.svh"
module cfa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  cfa_pkg::sts_t sts,
	output cfa_pkg::ctl_t ctl,
	output logic          busy,
	output logic          done
);

	cfa_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cfa_pkg::ST_BOOT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			cfa_pkg::ST_BOOT: begin
				if (sts.fill_done) state_d = cfa_pkg::ST_IDLE;
			end
			cfa_pkg::ST_IDLE: begin
				if (start) state_d = sts.go_scan ? cfa_pkg::ST_SCAN : cfa_pkg::ST_FILL;
			end
			cfa_pkg::ST_SCAN: begin
				if (sts.found) state_d = cfa_pkg::ST_FILL;
				else if (sts.exhausted) state_d = cfa_pkg::ST_RESP;
			end
			cfa_pkg::ST_FILL: begin
				if (sts.fill_done) state_d = cfa_pkg::ST_RESP;
			end
			cfa_pkg::ST_RESP: begin
				state_d = cfa_pkg::ST_IDLE;
			end
			default: begin
				state_d = cfa_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl.op = cfa_pkg::DP_HOLD;
		busy   = 1'b1;
		done   = 1'b0;
		case (state_q)
			cfa_pkg::ST_BOOT: begin
				ctl.op = cfa_pkg::DP_FILL;
			end
			cfa_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) ctl.op = cfa_pkg::DP_LOAD;
			end
			cfa_pkg::ST_SCAN: begin
				ctl.op = cfa_pkg::DP_SCAN;
			end
			cfa_pkg::ST_FILL: begin
				ctl.op = cfa_pkg::DP_FILL;
			end
			cfa_pkg::ST_RESP: begin
				done = 1'b1;
			end
			default: begin
				ctl.op = cfa_pkg::DP_HOLD;
			end
		endcase
	end

	`CFA_ASSERT_NEXT(a_done_one_cycle, done, !done)
	`CFA_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy && !done)
	`CFA_ASSERT_NEXT(a_done_then_idle, done, !busy)
	`CFA_ASSERT_SAME(a_scan_exits_clean, state_q == cfa_pkg::ST_SCAN,
		!(sts.found && sts.exhausted))

endmodule

>>> src/cfa_dpath.sv
// bitmap memory, scan pipeline and range writer of the frame allocator
`timescale 1ns / 1ps
module cfa_dpath #(
	parameter int NUM_FRAMES = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cfa_pkg::ctl_t                ctl,
	output cfa_pkg::sts_t                sts,
	input  logic [cfa_pkg::CMD_W-1:0]    cmd,
	input  logic [cfa_pkg::FRAME_W-1:0]  frame_start,
	input  logic [cfa_pkg::COUNT_W-1:0]  frame_count,
	input  logic                         cfg_we,
	input  logic                         cfg_sel,
	input  logic [cfa_pkg::COUNT_W-1:0]  cfg_wdata,
	output logic                         ok,
	output logic [cfa_pkg::FRAME_W-1:0]  first_frame
);

	localparam int AW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam int NW = AW + 1;
	localparam int CW = (NW > 12) ? NW : 12;
	localparam logic [NW-1:0] N_P = NW'(NUM_FRAMES);
	localparam logic [CW-1:0] N_C = CW'(NUM_FRAMES);

	logic mem [NUM_FRAMES];

	logic [cfa_pkg::FRAME_W-1:0] search_start_q;
	logic [cfa_pkg::COUNT_W-1:0] reserved_q;

	logic [NW-1:0] ptr_q, stop_q, split_q;
	logic          mark_val_q;
	logic [cfa_pkg::COUNT_W-1:0] count_q, run_q, run_n;
	logic          vld_s1, rd_s1;
	logic [NW-1:0] idx_s1;
	logic          ok_q;
	logic [cfa_pkg::FRAME_W-1:0] first_q;

	logic [CW-1:0] free_end, res_c, mark_first;
	logic          alloc_ok, free_ok, issue, fill_we;

	assign free_end   = CW'(frame_start) + CW'(frame_count);
	assign res_c      = (CW'(reserved_q) > N_C) ? N_C : CW'(reserved_q);
	assign alloc_ok   = (frame_count != '0) && (CW'(search_start_q) < N_C);
	assign free_ok    = (free_end <= N_C);
	assign issue      = (ptr_q < N_P);
	assign fill_we    = (ctl.op == cfa_pkg::DP_FILL) && (ptr_q != stop_q);
	assign run_n      = rd_s1 ? '0 : run_q + cfa_pkg::COUNT_W'(1);
	assign mark_first = CW'(idx_s1) + CW'(1) - CW'(count_q);

	assign sts.go_scan   = (cmd == cfa_pkg::CMD_ALLOC) && alloc_ok;
	assign sts.found     = vld_s1 && (run_n == count_q);
	assign sts.exhausted = !vld_s1 && !issue;
	assign sts.fill_done = (ptr_q == stop_q);

	assign ok          = ok_q;
	assign first_frame = first_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_start_q <= '0;
			reserved_q     <= '0;
		end else if (cfg_we) begin
			if (cfg_sel == cfa_pkg::REG_SEARCH_START) begin
				search_start_q <= cfg_wdata[cfa_pkg::FRAME_W-1:0];
			end else begin
				reserved_q <= cfg_wdata;
			end
		end
	end

	// bitmap: one read port for the scan, one write port for range fills
	always_ff @(posedge clk) begin
		if (fill_we) begin
			mem[ptr_q[AW-1:0]] <= (ptr_q < split_q) ? mark_val_q : 1'b0;
		end
		rd_s1  <= mem[ptr_q[AW-1:0]];
		idx_s1 <= ptr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// reset pass clears the whole map
			ptr_q      <= '0;
			stop_q     <= N_P;
			split_q    <= '0;
			mark_val_q <= 1'b0;
			vld_s1     <= 1'b0;
			run_q      <= '0;
			count_q    <= '0;
			ok_q       <= 1'b0;
			first_q    <= '0;
		end else begin
			case (ctl.op)
				cfa_pkg::DP_LOAD: begin
					vld_s1  <= 1'b0;
					run_q   <= '0;
					count_q <= frame_count;
					first_q <= '0;
					ok_q    <= 1'b0;
					ptr_q   <= '0;
					stop_q  <= '0;
					split_q <= '0;
					case (cmd)
						cfa_pkg::CMD_INIT: begin
							stop_q     <= N_P;
							split_q    <= res_c[NW-1:0];
							mark_val_q <= 1'b1;
							ok_q       <= 1'b1;
						end
						cfa_pkg::CMD_ALLOC: begin
							if (alloc_ok) ptr_q <= NW'(search_start_q);
						end
						cfa_pkg::CMD_FREE: begin
							if (free_ok) begin
								ptr_q      <= NW'(frame_start);
								stop_q     <= free_end[NW-1:0];
								split_q    <= free_end[NW-1:0];
								mark_val_q <= 1'b0;
								ok_q       <= 1'b1;
							end
						end
						default: begin
							ok_q <= 1'b0;
						end
					endcase
				end
				cfa_pkg::DP_SCAN: begin
					if (sts.found) begin
						// run ends at idx_s1: mark it and report its head
						ptr_q      <= mark_first[NW-1:0];
						stop_q     <= idx_s1 + NW'(1);
						split_q    <= idx_s1 + NW'(1);
						mark_val_q <= 1'b1;
						ok_q       <= 1'b1;
						first_q    <= mark_first[cfa_pkg::FRAME_W-1:0];
						vld_s1     <= 1'b0;
					end else begin
						vld_s1 <= issue;
						if (issue) ptr_q <= ptr_q + NW'(1);
						if (vld_s1) run_q <= run_n;
					end
				end
				cfa_pkg::DP_FILL: begin
					if (fill_we) ptr_q <= ptr_q + NW'(1);
				end
				default: begin
					vld_s1 <= 1'b0;
				end
			endcase
		end
	end

endmodule

>>> src/contiguous_frame_allocator_core.sv
// top level of the first-fit contiguous frame allocator
`timescale 1ns / 1ps
// First-fit frame allocator over a one-bit-per-frame bitmap memory. Pulse start while busy
// is low to issue init, alloc or free; exactly one result beat follows, shown for a single
// cycle with done high, and the receiver must take it then. All timing is set by the
// single bitmap memory, which is read or written one frame per cycle: init writes the
// whole map, free clears its range, and alloc scans upward from search_start and then
// marks the frames of the run it found. After reset the block stays busy while it
// clears the map; configuration writes are taken at any time but belong in idle periods.
module contiguous_frame_allocator_core #(
	parameter int NUM_FRAMES = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [cfa_pkg::CMD_W-1:0]    cmd,
	input  logic [cfa_pkg::FRAME_W-1:0]  frame_start,
	input  logic [cfa_pkg::COUNT_W-1:0]  frame_count,
	output logic                         done,
	output logic                         ok,
	output logic [cfa_pkg::FRAME_W-1:0]  first_frame,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic                         cfg_index,
	input  logic [cfa_pkg::COUNT_W-1:0]  cfg_data
);

	cfa_pkg::ctl_t ctl;
	cfa_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	cfa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	cfa_dpath #(
		.NUM_FRAMES (NUM_FRAMES)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.sts         (sts),
		.cmd         (cmd),
		.frame_start (frame_start),
		.frame_count (frame_count),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_sel     (cfg_index),
		.cfg_wdata   (cfg_data),
		.ok          (ok),
		.first_frame (first_frame)
	);

endmodule

>>> tb/tb.sv
// scoreboard-checked testbench of the first-fit contiguous frame allocator
`timescale 1ns / 1ps
module tb;

	localparam int FRAMES = 1024;
	localparam int CYCLE_LIMIT = 8000000;
	localparam int RAND_PER_PHASE = 92;
	localparam int CMD_W = cfa_pkg::CMD_W;
	localparam int FRAME_W = cfa_pkg::FRAME_W;
	localparam int COUNT_W = cfa_pkg::COUNT_W;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct {
		logic [CMD_W-1:0]   op;
		logic [FRAME_W-1:0] base;
		logic [COUNT_W-1:0] len;
	} frame_cmd_t;

	typedef struct {
		logic               granted;
		logic [FRAME_W-1:0] first;
	} frame_reply_t;

	class frame_map_board;
		bit [FRAMES-1:0]    frame_busy;
		logic [FRAME_W-1:0] scan_from;
		logic [COUNT_W-1:0] reserve_len;
		frame_reply_t       replies_due[$];
		int                 errors;
		int                 checked;
		int                 granted;
		int                 issued [4];

		function new();
			frame_busy = '0;
			scan_from = '0;
			reserve_len = '0;
			errors = 0;
			checked = 0;
			granted = 0;
			foreach (issued[k]) issued[k] = 0;
		endfunction

		function void set_reg(logic idx, logic [COUNT_W-1:0] data);
			if (idx == cfa_pkg::REG_SEARCH_START) scan_from = data[FRAME_W-1:0];
			else reserve_len = data;
		endfunction

		function int pending();
			return replies_due.size();
		endfunction

		function void note(frame_cmd_t c);
			frame_reply_t r;
			int run;
			int hit;
			int lo;
			r.granted = 1'b0;
			r.first = '0;
			run = 0;
			hit = -1;
			issued[c.op]++;
			case (c.op)
				cfa_pkg::CMD_INIT: begin
					lo = (int'(reserve_len) > FRAMES) ? FRAMES : int'(reserve_len);
					frame_busy = '0;
					for (int k = 0; k < lo; k++) frame_busy[k] = 1'b1;
					r.granted = 1'b1;
				end
				cfa_pkg::CMD_ALLOC: begin
					if (c.len != 0) begin
						for (int i = int'(scan_from); i < FRAMES; i++) begin
							if (frame_busy[i]) run = 0;
							else run++;
							if (run == int'(c.len)) begin
								hit = i;
								break;
							end
						end
					end
					if (hit >= 0) begin
						lo = hit + 1 - int'(c.len);
						for (int k = lo; k <= hit; k++) frame_busy[k] = 1'b1;
						r.granted = 1'b1;
						r.first = lo[FRAME_W-1:0];
						granted++;
					end
				end
				cfa_pkg::CMD_FREE: begin
					// a range running past the top frame is refused whole
					if (int'(c.base) + int'(c.len) <= FRAMES) begin
						for (int k = 0; k < int'(c.len); k++) frame_busy[int'(c.base) + k] = 1'b0;
						r.granted = 1'b1;
					end
				end
				default: ;
			endcase
			replies_due.push_back(r);
		endfunction

		task report(string what);
			$display("mismatch at %0t: %s", $time, what);
			errors++;
		endtask

		task check(logic got_ok, logic [FRAME_W-1:0] got_first);
			frame_reply_t want;
			if (replies_due.size() == 0) begin
				report($sformatf("reply ok=%b first=%0d with no command pending", got_ok, got_first));
			end else begin
				want = replies_due.pop_front();
				checked++;
				if (got_ok !== want.granted)
					report($sformatf("ok %b, expected %b", got_ok, want.granted));
				if (got_first !== want.first)
					report($sformatf("first_frame %0d, expected %0d", got_first, want.first));
			end
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [CMD_W-1:0]   cmd = cfa_pkg::CMD_INIT;
	logic [FRAME_W-1:0] frame_start = '0;
	logic [COUNT_W-1:0] frame_count = '0;
	logic               cfg_valid = 1'b0;
	logic               cfg_index = cfa_pkg::REG_SEARCH_START;
	logic [COUNT_W-1:0] cfg_data = '0;
	logic               busy;
	logic               done;
	logic               ok;
	logic [FRAME_W-1:0] first_frame;
	logic               cfg_ready;
	int                 cycles = 0;

	frame_map_board board = new();

	contiguous_frame_allocator_core #(
		.NUM_FRAMES(FRAMES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.frame_start(frame_start),
		.frame_count(frame_count),
		.done(done),
		.ok(ok),
		.first_frame(first_frame),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timed out after %0d cycles with %0d replies pending", cycles, board.pending());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// reply beat first, so a beat and a new command on one edge stay in order
	always @(posedge clk) begin
		if (arst_n && done) board.check(ok, first_frame);
		if (arst_n && start && !busy) board.note('{cmd, frame_start, frame_count});
	end

	function automatic frame_cmd_t mk(logic [CMD_W-1:0] op, int base, int len);
		frame_cmd_t c;
		c.op = op;
		c.base = FRAME_W'(base);
		c.len = COUNT_W'(len);
		return c;
	endfunction

	function automatic logic [COUNT_W-1:0] pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3) return '0;
		if (r < 70) return COUNT_W'($urandom_range(1, 16));
		if (r < 90) return COUNT_W'($urandom_range(17, 128));
		if (r < 97) return COUNT_W'($urandom_range(129, 1024));
		return COUNT_W'($urandom_range(1025, 2047));
	endfunction

	function automatic frame_cmd_t pick_cmd();
		frame_cmd_t c;
		int r;
		r = $urandom_range(0, 99);
		c.base = FRAME_W'($urandom_range(0, 255));
		c.len = pick_len();
		if (r < 6) begin
			c.op = cfa_pkg::CMD_INIT;
		end else if (r < 52) begin
			c.op = cfa_pkg::CMD_ALLOC;
		end else if (r < 88) begin
			c.op = cfa_pkg::CMD_FREE;
			if ($urandom_range(0, 7) == 0) c.base = FRAME_W'($urandom());
		end else if (r < 92) begin
			c.op = CMD_UNUSED;
		end else begin
			// noise: every field fully random
			c.op = CMD_W'($urandom());
			c.base = FRAME_W'($urandom());
			c.len = COUNT_W'($urandom());
		end
		return c;
	endfunction

	task automatic drive_cmd(frame_cmd_t c);
		start <= 1'b1;
		cmd <= c.op;
		frame_start <= c.base;
		frame_count <= c.len;
		do @(posedge clk); while (busy);
	endtask

	task automatic send_cmds(frame_cmd_t cmds[$], int idle_pct);
		int gap;
		int calm;
		calm = 0;
		foreach (cmds[j]) begin
			drive_cmd(cmds[j]);
			gap = 0;
			if (calm > 0) calm--;
			else if ($urandom_range(0, 99) < 3) calm = $urandom_range(10, 30);
			else if ($urandom_range(0, 99) < idle_pct)
				gap = ($urandom_range(0, 7) == 0) ? $urandom_range(65, 1200) : $urandom_range(1, 64);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		start <= 1'b0;
	endtask

	task automatic write_regs(logic [COUNT_W-1:0] from_data, logic [COUNT_W-1:0] reserve_data);
		cfg_valid <= 1'b1;
		cfg_index <= cfa_pkg::REG_SEARCH_START;
		cfg_data <= from_data;
		do @(posedge clk); while (!cfg_ready);
		board.set_reg(cfa_pkg::REG_SEARCH_START, from_data);
		cfg_index <= cfa_pkg::REG_RESERVED;
		cfg_data <= reserve_data;
		do @(posedge clk); while (!cfg_ready);
		board.set_reg(cfa_pkg::REG_RESERVED, reserve_data);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
		while (busy) @(posedge clk);
		@(posedge clk);
	endtask

	initial begin
		frame_cmd_t         plan[$];
		logic [COUNT_W-1:0] from_v;
		logic [COUNT_W-1:0] res_v;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		// map clearing pass after reset
		repeat (2) @(posedge clk);
		while (busy) @(posedge clk);

		write_regs(11'd0, 11'd16);
		plan.push_back(mk(cfa_pkg::CMD_INIT, 0, 0));
		plan.push_back(mk(cfa_pkg::CMD_ALLOC, 0, 0));
		plan.push_back(mk(cfa_pkg::CMD_ALLOC, 0, 1));
		plan.push_back(mk(cfa_pkg::CMD_ALLOC, 0, 1024));
		plan.push_back(mk(cfa_pkg::CMD_ALLOC, 1023, 5));
		plan.push_back(mk(cfa_pkg::CMD_FREE, 0, 0));
		plan.push_back(mk(cfa_pkg::CMD_FREE, 1023, 2));
		plan.push_back(mk(cfa_pkg::CMD_FREE, 1020, 4));
		plan.push_back(mk(cfa_pkg::CMD_FREE, 0, 1024));
		plan.push_back(mk(cfa_pkg::CMD_ALLOC, 0, 1024));
		plan.push_back(mk(cfa_pkg::CMD_ALLOC, 0, 1));
		plan.push_back(mk(CMD_UNUSED, 1023, 2047));
		plan.push_back(mk(cfa_pkg::CMD_FREE, 1023, 2047));
		plan.push_back(mk(cfa_pkg::CMD_ALLOC, 0, 2047));
		plan.push_back(mk(cfa_pkg::CMD_FREE, 0, 1024));
		plan.push_back(mk(cfa_pkg::CMD_FREE, 1023, 1));
		plan.push_back(mk(cfa_pkg::CMD_ALLOC, 0, 7));
		plan.push_back(mk(cfa_pkg::CMD_FREE, 3, 1));
		plan.push_back(mk(cfa_pkg::CMD_ALLOC, 0, 2));
		plan.push_back(mk(cfa_pkg::CMD_ALLOC, 0, 1));
		plan.push_back(mk(cfa_pkg::CMD_INIT, 1023, 2047));
		send_cmds(plan, 0);
		wait_idle();

		// top search start, reserve count above the map size
		write_regs(11'h7FF, 11'h7FF);
		plan.delete();
		plan.push_back(mk(cfa_pkg::CMD_INIT, 0, 0));
		plan.push_back(mk(cfa_pkg::CMD_ALLOC, 0, 1));
		plan.push_back(mk(cfa_pkg::CMD_FREE, 1023, 1));
		plan.push_back(mk(cfa_pkg::CMD_ALLOC, 0, 2));
		plan.push_back(mk(cfa_pkg::CMD_ALLOC, 0, 1));
		send_cmds(plan, 0);
		wait_idle();

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: begin
					from_v = 11'd0;
					res_v = 11'd0;
				end
				1: begin
					from_v = COUNT_W'($urandom_range(0, 127));
					res_v = COUNT_W'($urandom_range(0, 300));
				end
				2: begin
					from_v = COUNT_W'($urandom());
					res_v = 11'd1024;
				end
				3: begin
					from_v = 11'd0;
					res_v = COUNT_W'($urandom());
				end
				4: begin
					from_v = 11'd512;
					res_v = 11'd600;
				end
				default: begin
					from_v = COUNT_W'($urandom_range(0, 31));
					res_v = COUNT_W'($urandom_range(0, 64));
				end
			endcase
			write_regs(from_v, res_v);
			plan.delete();
			plan.push_back(mk(cfa_pkg::CMD_INIT, 0, 0));
			repeat (RAND_PER_PHASE) plan.push_back(pick_cmd());
			send_cmds(plan, (p < 2) ? 27 : (p < 4) ? 63 : 0);
			wait_idle();
		end

		repeat (16) @(posedge clk);
		$display("covered %0d commands: %0d init, %0d alloc, %0d free, %0d undefined, 8 settings",
			board.issued[cfa_pkg::CMD_INIT] + board.issued[cfa_pkg::CMD_ALLOC] +
			board.issued[cfa_pkg::CMD_FREE] + board.issued[CMD_UNUSED],
			board.issued[cfa_pkg::CMD_INIT], board.issued[cfa_pkg::CMD_ALLOC],
			board.issued[cfa_pkg::CMD_FREE], board.issued[CMD_UNUSED]);
		$display("%0d replies compared, %0d allocations granted, %0d mismatches in %0d cycles",
			board.checked, board.granted, board.errors, cycles);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule

>>> sim.f
+incdir+src
src/cfa_pkg.sv
src/cfa_ctrl.sv
src/cfa_dpath.sv
src/contiguous_frame_allocator_core.sv
tb/tb.sv
